[src/lled_pkg.sv]
// Shared types, constants and codes for the light level edge detector.
`timescale 1ns / 1ps
`default_nettype none

package lled_pkg;

    // Fixed-point layout of a tracked level
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int LEVEL_BITS    = SAMPLE_BITS + FRACTION_BITS;

    // Register widths
    localparam int THRESH_BITS = 16;
    localparam int COUNT_BITS  = 8;
    localparam int GAIN_BITS   = 16;
    localparam int CMP_BITS    = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    // Register reset values
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(64);
    localparam logic [COUNT_BITS-1:0]  SETTLE_RESET = COUNT_BITS'(8);
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(3277);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = '1;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = 2'd2;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_SEED   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Edge event codes
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_RISE = 2'd1,
        EV_FALL = 2'd2
    } event_t;

    // Detector state
    typedef struct packed {
        logic                   pending;
        logic [COUNT_BITS-1:0]  counter;
        logic [LEVEL_BITS-1:0]  baseline;
        logic [LEVEL_BITS-1:0]  candidate;
        logic [SAMPLE_BITS-1:0] prev;
    } det_state_t;

    // Configuration registers
    typedef struct packed {
        logic [THRESH_BITS-1:0] threshold;
        logic [COUNT_BITS-1:0]  settle;
        logic [GAIN_BITS-1:0]   gain;
    } det_cfg_t;

endpackage

`default_nettype wire

[src/lled_step.sv]
// Next-state and edge event logic for one detector item.
`timescale 1ns / 1ps
`default_nettype none

module lled_step (
    input  wire logic [1:0]                     op,
    input  wire logic [lled_pkg::SAMPLE_BITS-1:0] smp,
    input  wire lled_pkg::det_state_t           cur,
    input  wire lled_pkg::det_cfg_t             cfg,
    output lled_pkg::det_state_t                nxt,
    output logic [1:0]                          ev
);
    import lled_pkg::*;

    logic [SAMPLE_BITS+1:0]        filt_sum;
    logic [SAMPLE_BITS-1:0]        filt;
    logic [SAMPLE_BITS-1:0]        base_whole;
    logic [SAMPLE_BITS-1:0]        cand_whole;
    logic [SAMPLE_BITS-1:0]        base_dist;
    logic [SAMPLE_BITS-1:0]        cand_dist;
    logic                          near_base;
    logic                          near_cand;
    logic [LEVEL_BITS-1:0]         filt_level;
    logic [LEVEL_BITS-1:0]         track_in;
    logic signed [LEVEL_BITS:0]    track_diff;
    logic signed [LEVEL_BITS+GAIN_BITS+1:0] track_prod;
    logic signed [LEVEL_BITS+GAIN_BITS+1:0] track_step;
    logic [LEVEL_BITS-1:0]         track_out;
    logic [COUNT_BITS-1:0]         count_inc;

    function automatic logic [LEVEL_BITS-1:0] filt_level_of_seed(
        input logic [SAMPLE_BITS-1:0] raw
    );
        return {raw, {FRACTION_BITS{1'b0}}};
    endfunction

    // Smooth against the previous raw sample: (3*prev + cur) >> 2
    assign filt_sum = {2'b00, cur.prev} + {1'b0, cur.prev, 1'b0} + {2'b00, smp};
    assign filt     = filt_sum[SAMPLE_BITS+1:2];
    assign filt_level = {filt, {FRACTION_BITS{1'b0}}};

    // Distance of the filtered sample to the integer part of each level
    assign base_whole = cur.baseline[LEVEL_BITS-1:FRACTION_BITS];
    assign cand_whole = cur.candidate[LEVEL_BITS-1:FRACTION_BITS];
    assign base_dist  = (filt > base_whole) ? filt - base_whole : base_whole - filt;
    assign cand_dist  = (filt > cand_whole) ? filt - cand_whole : cand_whole - filt;
    assign near_base  = CMP_BITS'(base_dist) < CMP_BITS'(cfg.threshold);
    assign near_cand  = CMP_BITS'(cand_dist) < CMP_BITS'(cfg.threshold);

    // First-order tracking: level + ((F - level) * g) >>> 16, one multiplier
    // shared by baseline (stable phase) and candidate (pending phase)
    assign track_in   = cur.pending ? cur.candidate : cur.baseline;
    assign track_diff = $signed({1'b0, filt_level}) - $signed({1'b0, track_in});
    assign track_prod = track_diff * $signed({1'b0, cfg.gain});
    assign track_step = track_prod >>> GAIN_BITS;
    assign track_out  = track_in + track_step[LEVEL_BITS-1:0];

    // Saturating settle count
    assign count_inc = (cur.counter < COUNT_MAX) ? cur.counter + 1'b1 : cur.counter;

    always_comb begin
        nxt = cur;
        ev  = EV_NONE;
        case (op)
            OP_SEED: begin
                nxt.baseline = filt_level_of_seed(smp);
                nxt.prev     = smp;
            end
            OP_CLEAR: begin
                nxt.pending   = 1'b0;
                nxt.counter   = '0;
                nxt.baseline  = '0;
                nxt.candidate = '0;
            end
            OP_SAMPLE: begin
                nxt.prev = smp;
                if (!cur.pending) begin
                    if (near_base) begin
                        nxt.baseline = track_out;
                    end else begin
                        nxt.pending   = 1'b1;
                        nxt.candidate = filt_level;
                        nxt.counter   = COUNT_BITS'(1);
                    end
                end else if (near_cand) begin
                    nxt.candidate = track_out;
                    nxt.counter   = count_inc;
                    if (count_inc >= cfg.settle) begin
                        nxt.pending  = 1'b0;
                        nxt.baseline = track_out;
                        nxt.counter  = '0;
                        ev = (track_out > cur.baseline) ? EV_RISE : EV_FALL;
                    end
                end else if (near_base) begin
                    // back near the baseline: drop the candidate
                    nxt.pending = 1'b0;
                    nxt.counter = '0;
                end else begin
                    // another jump: restart the candidate here
                    nxt.candidate = filt_level;
                    nxt.counter   = COUNT_BITS'(1);
                end
            end
            default: begin
                // unused code: state kept
            end
        endcase
    end

endmodule

`default_nettype wire

[src/light_level_edge_detector_core.sv]
// Top level of the light level edge detector: stream ports, registers, state.
`timescale 1ns / 1ps
`default_nettype none

// Light level edge detector. Each transfer on the s_ channel carries an
// operation on s_tuser (sample, seed, clear) and a raw 16-bit reading on
// s_tdata; each one produces exactly one transfer on the m_ channel with the
// edge event (none, rising, falling). The block takes one item per clock
// while the m_ side takes each result: the state update for an item
// completes in the cycle it is accepted, and its result appears on m_tvalid
// the next cycle. The per-item path is the filter, the distance compares and
// one 33x17 tracking multiply feeding the state registers. The result
// register frees s_tready again as soon as the m_ side takes the waiting
// result. Configuration writes (threshold, settle count, tracking gain) are
// always accepted and should be issued only while no item is in flight.
module light_level_edge_detector_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [1:0] edge_event, [7:2] zero
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [lled_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    import lled_pkg::*;

    det_cfg_t   cfg_reg;
    det_state_t state_reg;
    det_state_t state_next;
    logic       m_valid_reg;
    logic [1:0] event_reg;
    logic [1:0] event_next;
    logic       s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, event_reg};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= THRESH_RESET;
            cfg_reg.settle    <= SETTLE_RESET;
            cfg_reg.gain      <= GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD: cfg_reg.threshold <= cfg_data[THRESH_BITS-1:0];
                REG_SETTLE:    cfg_reg.settle    <= cfg_data[COUNT_BITS-1:0];
                REG_GAIN:      cfg_reg.gain      <= cfg_data[GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Per-item detector logic
    lled_step u_step (
        .op  (s_tuser),
        .smp (s_tdata[SAMPLE_BITS-1:0]),
        .cur (state_reg),
        .cfg (cfg_reg),
        .nxt (state_next),
        .ev  (event_next)
    );

    // Detector state, updated on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            event_reg <= event_next;
        end
    end

    // The settle counter runs exactly while a candidate is pending
    a_counter_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.pending == (state_reg.counter != '0)))
        else $error("settle counter out of step with pending phase");

    // Seed, clear and unused codes never report an edge
    a_no_event_on_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser != OP_SAMPLE) |=> (event_reg == EV_NONE))
        else $error("edge reported for a non-sample operation");

    // A rising edge moves the baseline up
    a_rise_raises: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && event_next == EV_RISE) |=>
            (state_reg.baseline > $past(state_reg.baseline)))
        else $error("rising edge without a higher baseline");

    // A falling edge never moves the baseline up
    a_fall_not_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && event_next == EV_FALL) |=>
            (state_reg.baseline <= $past(state_reg.baseline)))
        else $error("falling edge with a higher baseline");

endmodule

`default_nettype wire
